// File: hdl/pelco_d_response_deframer_defines.svh
// ---------------------------------------------------------------------------
// pelco_d_response_deframer_defines
// assertion macros shared by the response deframer rtl
// ---------------------------------------------------------------------------
`ifndef PELCO_D_RESPONSE_DEFRAMER_DEFINES_SVH
`define PELCO_D_RESPONSE_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PDRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdrd same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PDRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdrd next-cycle check failed");

`endif

// File: hdl/pdrd_pkg.sv
// ---------------------------------------------------------------------------
// pdrd_pkg
// constants and types of the response deframer
// ---------------------------------------------------------------------------
package pdrd_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] RESP_ZOOM  = 8'hA7;
  localparam logic [7:0] RESP_FOCUS = 8'h63;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_ZOOM  = 2'd1,
    KIND_FOCUS = 2'd2
  } report_kind_t;

  // one state per frame slot, hunt waits for sync
  typedef enum logic [6:0] {
    ST_HUNT    = 7'b0000001,
    ST_ADDR    = 7'b0000010,
    ST_RESP1   = 7'b0000100,
    ST_RESP2   = 7'b0001000,
    ST_DATA_HI = 7'b0010000,
    ST_DATA_LO = 7'b0100000,
    ST_CSUM    = 7'b1000000
  } frame_state_t;

endpackage

// File: hdl/pelco_d_response_deframer.sv
// ---------------------------------------------------------------------------
// pelco_d_response_deframer
// seven-byte camera response frame receiver with checksum and report class
// ---------------------------------------------------------------------------
// One received byte enters per item on the in_ channel. While hunting, any
// byte other than 0xFF is dropped; after a sync the next six bytes are always
// taken as address, two response bytes, data high, data low and checksum, with
// no resync inside the frame. When the 8-bit sum of the five bytes between
// sync and checksum matches the checksum, one report item goes out: kind
// (zoom for response 0xA7, focus for 0x63, else other), the big-endian 16-bit
// position and the second response byte. Bad frames give no item. The block
// takes one byte per cycle while in_stall is low: a byte is held in the input
// register, the frame tracker acts on it, and a report lands in the output
// register; a checksum byte thus passes both registers before its report goes
// out. in_stall only rises while a report waits in the output register and the
// held byte is a checksum that would produce another one.
`include "pelco_d_response_deframer_defines.svh"

module pelco_d_response_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_report_kind,
  output logic [15:0] out_position,
  output logic [7:0]  out_response_code
);

  import pdrd_pkg::*;

  // input register
  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;

  // frame tracker
  frame_state_t state_r, state_nxt;
  logic [7:0]   sum_r, sum_nxt;
  logic [7:0]   resp_r, resp_nxt;
  logic [7:0]   data_hi_r, data_hi_nxt;
  logic [7:0]   data_lo_r, data_lo_nxt;

  // output register
  logic         out_valid_r, out_valid_nxt;
  report_kind_t kind_r, kind_nxt;
  logic [15:0]  pos_r;
  logic [7:0]   code_r;

  logic         in_fire;
  logic         s1_emit;
  logic         s1_go;
  logic         s1_fire;
  logic         out_free;

  // output register can take a new report this cycle
  assign out_free = !out_valid_r || !out_stall;

  // held byte would complete a good frame
  assign s1_emit  = s1_valid_r && (state_r == ST_CSUM) && (s1_byte_r == sum_r);

  // held byte leaves unless its report has nowhere to go
  assign s1_go    = !s1_emit || out_free;
  assign s1_fire  = s1_valid_r && s1_go;

  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // frame tracking, one byte per fire
  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    resp_nxt    = resp_r;
    data_hi_nxt = data_hi_r;
    data_lo_nxt = data_lo_r;
    if (s1_fire) begin
      case (state_r)
        ST_ADDR: begin
          sum_nxt   = sum_r + s1_byte_r;
          state_nxt = ST_RESP1;
        end
        ST_RESP1: begin
          sum_nxt   = sum_r + s1_byte_r;
          state_nxt = ST_RESP2;
        end
        ST_RESP2: begin
          resp_nxt  = s1_byte_r;
          sum_nxt   = sum_r + s1_byte_r;
          state_nxt = ST_DATA_HI;
        end
        ST_DATA_HI: begin
          data_hi_nxt = s1_byte_r;
          sum_nxt     = sum_r + s1_byte_r;
          state_nxt   = ST_DATA_LO;
        end
        ST_DATA_LO: begin
          data_lo_nxt = s1_byte_r;
          sum_nxt     = sum_r + s1_byte_r;
          state_nxt   = ST_CSUM;
        end
        ST_CSUM: begin
          // frame ends here whether or not the checksum matched
          state_nxt = ST_HUNT;
        end
        default: begin
          // hunting: only the sync byte opens a frame
          if (s1_byte_r == SYNC_BYTE) begin
            sum_nxt   = 8'd0;
            state_nxt = ST_ADDR;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      endcase
    end
  end

  // report class from the held second response byte
  always_comb begin
    if (resp_r == RESP_ZOOM) begin
      kind_nxt = KIND_ZOOM;
    end else if (resp_r == RESP_FOCUS) begin
      kind_nxt = KIND_FOCUS;
    end else begin
      kind_nxt = KIND_OTHER;
    end
  end

  always_comb begin
    if (s1_emit && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= ST_HUNT;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
    resp_r    <= resp_nxt;
    data_hi_r <= data_hi_nxt;
    data_lo_r <= data_lo_nxt;
    if (s1_emit && out_free) begin
      kind_r <= kind_nxt;
      pos_r  <= {data_hi_r, data_lo_r};
      code_r <= resp_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_report_kind   = kind_r;
  assign out_position      = pos_r;
  assign out_response_code = code_r;

  // tracker always sits in exactly one frame slot
  `PDRD_ASSERT_IMPL(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  // a consumed checksum byte always returns the tracker to hunting
  `PDRD_ASSERT_NEXT(a_csum_ends_frame, clk, rst_n,
                    s1_fire && (state_r == ST_CSUM), state_r == ST_HUNT)
  // input back-pressure only comes from a blocked report
  `PDRD_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall,
                    out_valid_r && out_stall && s1_emit)
  // a good frame always yields a report with a legal kind
  `PDRD_ASSERT_NEXT(a_emit_lands, clk, rst_n, s1_emit && out_free,
                    out_valid_r && (kind_r != 2'd3))

endmodule

// File: tb/sv/pdrd_report_checker.sv
// ---------------------------------------------------------------------------
// pdrd_report_checker
// follows the byte stream of the response deframer and checks its reports
// ---------------------------------------------------------------------------
// Tracks every accepted byte through its own frame tracker. A good checksum
// queues the report it should give. Each accepted report is compared field by
// field with the oldest queued one. Mismatches and reports still owed are
// handed to the top.
module pdrd_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_report_kind,
  input  logic [15:0] out_position,
  input  logic [7:0]  out_response_code,
  output int          mismatches,
  output int          reports_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import pdrd_pkg::*;

  typedef struct packed {
    report_kind_t kind;
    logic [15:0]  position;
    logic [7:0]   code;
  } frame_report_t;

  frame_state_t  slot;
  logic [7:0]    frame_sum;
  logic [7:0]    resp_code;
  logic [7:0]    data_hi;
  logic [7:0]    data_lo;
  frame_report_t reports_due[$];

  // one byte through the frame tracker, queues a report on a good checksum
  function automatic void track_frame_byte(input logic [7:0] b);
    frame_report_t rep;
    case (slot)
      ST_ADDR, ST_RESP1: begin
        frame_sum = frame_sum + b;
        slot      = (slot == ST_ADDR) ? ST_RESP1 : ST_RESP2;
      end
      ST_RESP2: begin
        resp_code = b;
        frame_sum = frame_sum + b;
        slot      = ST_DATA_HI;
      end
      ST_DATA_HI: begin
        data_hi   = b;
        frame_sum = frame_sum + b;
        slot      = ST_DATA_LO;
      end
      ST_DATA_LO: begin
        data_lo   = b;
        frame_sum = frame_sum + b;
        slot      = ST_CSUM;
      end
      ST_CSUM: begin
        slot = ST_HUNT;
        if (b == frame_sum) begin
          if (resp_code == RESP_ZOOM) rep.kind = KIND_ZOOM;
          else if (resp_code == RESP_FOCUS) rep.kind = KIND_FOCUS;
          else rep.kind = KIND_OTHER;
          rep.position = {data_hi, data_lo};
          rep.code     = resp_code;
          reports_due  = {reports_due, rep};
        end
      end
      default: begin
        if (b == SYNC_BYTE) begin
          frame_sum = '0;
          slot      = ST_ADDR;
        end else begin
          slot = ST_HUNT;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t ns: report mismatch on %s, expected %0h, got %0h",
             $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    if (!rst_n) begin
      slot      = ST_HUNT;
      frame_sum = '0;
      resp_code = '0;
      data_hi   = '0;
      data_lo   = '0;
      reports_due.delete();
    end else begin
      if (in_valid && !in_stall) track_frame_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          report_mismatch("report with none owed, position", 16'h0, out_position);
        end else begin
          want = reports_due.pop_front();
          if (out_report_kind !== want.kind)
            report_mismatch("report_kind", 16'(want.kind), 16'(out_report_kind));
          if (out_position !== want.position)
            report_mismatch("position", want.position, out_position);
          if (out_response_code !== want.code)
            report_mismatch("response_code", 16'(want.code), 16'(out_response_code));
        end
      end
    end
    reports_owed = reports_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the response deframer
// ---------------------------------------------------------------------------
// Feeds received bytes into the deframer: a few hand-built frames first,
// then random frames with random content, bad checksums and line noise.
// Both sides idle at random, apart from one stretch where neither does, and
// once the report side holds off long enough that the block backs up into
// its byte input. The checker beside the block predicts and compares.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pdrd_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_report_kind;
  logic [15:0] out_position;
  logic [7:0]  out_response_code;

  int mismatches;
  int reports_owed;
  int frame_items;   // bytes sent as part of built frames
  bit idle_on;       // random gaps and stalls allowed
  bit hold_req;      // asks the report side for one long hold-off

  pelco_d_response_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_report_kind   (out_report_kind),
    .out_position      (out_position),
    .out_response_code (out_response_code)
  );

  pdrd_report_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_report_kind   (out_report_kind),
    .out_position      (out_position),
    .out_response_code (out_response_code),
    .mismatches        (mismatches),
    .reports_owed      (reports_owed)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one byte item: optional gap cycles, then offer until accepted
  task automatic put_byte(input logic [7:0] b);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // full seven-byte frame, checksum optionally broken by a nonzero offset
  task automatic put_frame(input logic [7:0] addr, input logic [7:0] resp1,
                           input logic [7:0] resp2, input logic [7:0] hi,
                           input logic [7:0] lo, input bit bad_sum);
    logic [7:0] csum;
    csum = addr + resp1 + resp2 + hi + lo;
    if (bad_sum) csum = csum + 8'($urandom_range(255, 1));
    put_byte(SYNC_BYTE);
    put_byte(addr);
    put_byte(resp1);
    put_byte(resp2);
    put_byte(hi);
    put_byte(lo);
    put_byte(csum);
    frame_items += 7;
  endtask

  // mostly good zoom or focus reports, some other codes and bad checksums,
  // now and then a burst of line noise that may itself hold a sync
  task automatic random_traffic(input int until_items);
    int         pick;
    logic [7:0] resp2;
    logic [15:0] pos;
    while (frame_items < until_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(4, 1))
          put_byte(($urandom_range(99) < 10) ? SYNC_BYTE : 8'($urandom_range(254)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) resp2 = RESP_ZOOM;
        else if (pick < 70) resp2 = RESP_FOCUS;
        else resp2 = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 8) pos = 16'h0000;
        else if (pick < 16) pos = 16'hFFFF;
        else pos = 16'($urandom);
        put_frame(8'($urandom), 8'($urandom), resp2, pos[15:8], pos[7:0],
                  $urandom_range(99) < 12);
      end
    end
  endtask

  // report side: random stalls, or one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 17);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    frame_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // noise while hunting is dropped
    put_byte(8'h00);
    put_byte(8'h7E);
    // sync byte used as address and data, zoom at top position
    put_frame(SYNC_BYTE, SYNC_BYTE, RESP_ZOOM, 8'hFF, 8'hFF, 1'b0);
    // focus at position zero, address and first response byte also zero
    put_frame(8'h00, 8'h00, RESP_FOCUS, 8'h00, 8'h00, 1'b0);
    // other response still carries its position
    put_frame(8'h5A, 8'hA5, 8'h01, 8'h12, 8'h34, 1'b0);
    // bad checksum gives nothing, next frame must still be found
    put_frame(8'h01, 8'h00, RESP_ZOOM, 8'h80, 8'h7F, 1'b1);

    random_traffic(450);

    // stretch with no gaps and no stalls
    idle_on = 1'b0;
    random_traffic(900);
    idle_on = 1'b1;

    // long hold-off on the report side while good frames keep coming
    hold_req = 1'b1;
    repeat (10)
      put_frame(8'($urandom), 8'($urandom), RESP_FOCUS, 8'($urandom), 8'($urandom), 1'b0);

    random_traffic(1300);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (reports_owed == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
